// ===== rtl/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg: shared definitions for the window median filter
// Field widths, register indexes, reset values and the stage control word.
// ----------------------------------------------------------------------------
package wmf_pkg;

   // default kernel and line geometry
   localparam int DEF_KERNEL_HEIGHT = 3;
   localparam int DEF_KERNEL_WIDTH  = 3;
   localparam int DEF_MAX_WIDTH     = 1024;

   // field widths
   localparam int PIX_W      = 8;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int ROW_W      = 12;
   localparam int DIM_W      = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int MAX_HEIGHT = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // register reset values
   localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
   localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   // control word carried down the pipeline with each transfer
   typedef struct packed {
      logic pix;     // item carries a pixel (window shifts)
      logic emit;    // item produces a result
      logic border;  // result is a copied border pixel
      logic last;    // result is the last pixel of a frame
      logic bypass;  // border pixel is the one being written
   } ctl_type;

endpackage

// ===== rtl/wmf_line_buf.sv =====
// ----------------------------------------------------------------------------
// wmf_line_buf: one line slot of the filter's line store
// Single write port, two registered read ports (window column and border).
// ----------------------------------------------------------------------------
module wmf_line_buf #(
   parameter int DEPTH = wmf_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [wmf_pkg::PIX_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   output logic [wmf_pkg::PIX_W-1:0] rd_data_a,
   output logic [wmf_pkg::PIX_W-1:0] rd_data_b
);

   logic [wmf_pkg::PIX_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/wmf_win_col.sv =====
// ----------------------------------------------------------------------------
// wmf_win_col: one column of window cells
// Each cell takes its neighbour's value on every shift.
// ----------------------------------------------------------------------------
module wmf_win_col #(
   parameter int ROWS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic [wmf_pkg::PIX_W-1:0] col_in  [ROWS],
   output logic [wmf_pkg::PIX_W-1:0] col_out [ROWS]
);

   logic [wmf_pkg::PIX_W-1:0] cell_ff [ROWS];

   // window cells clear to zero, then shift one column per pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            cell_ff[r] <= '0;
         end
      end else if (shift) begin
         for (int r = 0; r < ROWS; r++) begin
            cell_ff[r] <= col_in[r];
         end
      end
   end

   assign col_out = cell_ff;

endmodule

// ===== rtl/wmf_median.sv =====
// ----------------------------------------------------------------------------
// wmf_median: rank-based median of the window
// Stage 1 registers all pairwise compares, stage 2 the ranks; the element
// whose rank is the middle one is selected after stage 2.
// ----------------------------------------------------------------------------
module wmf_median #(
   parameter int N = 9
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [wmf_pkg::PIX_W-1:0] win [N],
   output logic [wmf_pkg::PIX_W-1:0] median
);

   localparam int NW  = $clog2(N + 1);
   localparam int MID = (N - 1) / 2;

   logic [N-1:0]              cmp_ff  [N];
   logic [N-1:0]              cmp_in  [N];
   logic [wmf_pkg::PIX_W-1:0] val1_ff [N];
   logic [wmf_pkg::PIX_W-1:0] val2_ff [N];
   logic [NW-1:0]             rank_ff [N];
   logic [NW-1:0]             rank_in [N];

   // element j ranks below k if smaller, or equal with lower index
   always_comb begin
      for (int k = 0; k < N; k++) begin
         for (int j = 0; j < N; j++) begin
            cmp_in[k][j] = (win[j] < win[k]) || ((win[j] == win[k]) && (j < k));
         end
      end
   end

   // rank of each element
   always_comb begin
      for (int k = 0; k < N; k++) begin
         rank_in[k] = NW'($countones(cmp_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_ff  <= cmp_in;
         val1_ff <= win;
         rank_ff <= rank_in;
         val2_ff <= val1_ff;
      end
   end

   // ranks form a permutation: exactly one element matches
   always_comb begin
      median = '0;
      for (int k = 0; k < N; k++) begin
         if (rank_ff[k] == NW'(MID)) begin
            median = median | val2_ff[k];
         end
      end
   end

endmodule

// ===== rtl/window_median_filter.sv =====
// ----------------------------------------------------------------------------
// window_median_filter: streaming 2-D median filter for 8-bit grey pixels
// Line store, shifting window of cells and a rank-based median pipeline.
// ----------------------------------------------------------------------------
// One item is taken every clock while the result side keeps up; a result
// passes the stage registers and the output register. Line slots are one
// memory each, written and read in the same cycle, and the window is a row
// of cell columns that shift once per pixel. Border pixels are copied from
// the store; interior pixels are the median of the window. Output trails
// input by half a kernel of rows and columns; flush items drain the tail.
// Frame sizes are saturated to [kernel, MAX_WIDTH] and [kernel, 4096].
module window_median_filter #(
   parameter int KERNEL_HEIGHT = wmf_pkg::DEF_KERNEL_HEIGHT,
   parameter int KERNEL_WIDTH  = wmf_pkg::DEF_KERNEL_WIDTH,
   parameter int MAX_WIDTH     = wmf_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wmf_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                          req_flush,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wmf_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_frame_last,
   input  logic                          csr_write_en,
   input  logic [wmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wmf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int HH       = (KERNEL_HEIGHT - 1) / 2;
   localparam int HW       = (KERNEL_WIDTH - 1) / 2;
   localparam int WR       = 2 * HH + 1;
   localparam int WC       = 2 * HW + 1;
   localparam int N        = WR * WC;
   localparam int SLOTS    = KERNEL_HEIGHT;
   localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int DW       = wmf_pkg::DIM_W;
   localparam int RW       = wmf_pkg::ROW_W;
   localparam int PEND_MAX = HH * MAX_WIDTH + HW;
   localparam int PW       = $clog2(PEND_MAX + 2);
   localparam int PIX_W    = wmf_pkg::PIX_W;

   // configuration registers
   logic [wmf_pkg::FW_W-1:0] frame_width_ff;
   logic [wmf_pkg::FH_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= wmf_pkg::RESET_FRAME_WIDTH;
         frame_height_ff <= wmf_pkg::RESET_FRAME_HEIGHT;
      end else if (csr_write_en) begin
         if (csr_index == wmf_pkg::REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[wmf_pkg::FW_W-1:0];
         end
         if (csr_index == wmf_pkg::REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata[wmf_pkg::FH_W-1:0];
         end
      end
   end

   // saturated frame size and output lag
   logic [DW-1:0] eff_w;
   logic [DW-1:0] eff_h;
   logic [PW-1:0] lag;

   always_comb begin
      eff_w = DW'(frame_width_ff);
      if (eff_w < DW'(KERNEL_WIDTH)) eff_w = DW'(KERNEL_WIDTH);
      if (eff_w > DW'(MAX_WIDTH))    eff_w = DW'(MAX_WIDTH);
      eff_h = DW'(frame_height_ff);
      if (eff_h < DW'(KERNEL_HEIGHT))        eff_h = DW'(KERNEL_HEIGHT);
      if (eff_h > DW'(wmf_pkg::MAX_HEIGHT))  eff_h = DW'(wmf_pkg::MAX_HEIGHT);
      lag = PW'(HH * eff_w + HW);
   end

   // pipeline advance: output register free or being taken
   logic rsp_valid_ff;
   logic adv;
   logic accept;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // position counters
   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [RW-1:0] in_row_ff, out_row_ff;
   logic [SW-1:0] in_slot_ff, out_slot_ff;
   logic [PW-1:0] pend_ff;

   logic [CW:0]   in_col_nx, out_col_nx;
   logic [RW:0]   in_row_nx, out_row_nx;
   logic [SW-1:0] in_slot_nx, out_slot_nx;
   logic [PW-1:0] pend_inc;
   logic          is_pix;
   logic          do_emit;
   logic          is_border;
   logic          is_last;

   always_comb begin
      is_pix    = !req_flush;
      pend_inc  = pend_ff + PW'(1);
      do_emit   = is_pix ? (pend_inc > lag) : (pend_ff != '0);
      is_border = (DW'(out_row_ff) < DW'(HH)) || (DW'(out_row_ff) + DW'(HH) >= eff_h) ||
                  (DW'(out_col_ff) < DW'(HW)) || (DW'(out_col_ff) + DW'(HW) >= eff_w);
      is_last   = (DW'(out_row_ff) + DW'(1) >= eff_h) && (DW'(out_col_ff) + DW'(1) >= eff_w);
      in_col_nx   = {1'b0, in_col_ff} + (CW+1)'(1);
      in_row_nx   = {1'b0, in_row_ff} + (RW+1)'(1);
      in_slot_nx  = (in_slot_ff == SW'(SLOTS - 1)) ? '0 : in_slot_ff + SW'(1);
      out_col_nx  = {1'b0, out_col_ff} + (CW+1)'(1);
      out_row_nx  = {1'b0, out_row_ff} + (RW+1)'(1);
      out_slot_nx = (out_slot_ff == SW'(SLOTS - 1)) ? '0 : out_slot_ff + SW'(1);
   end

   // input and output position tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pend_ff     <= '0;
      end else if (accept) begin
         if (is_pix) begin
            if (DW'(in_col_nx) >= eff_w) begin
               in_col_ff  <= '0;
               in_slot_ff <= in_slot_nx;
               in_row_ff  <= (DW'(in_row_nx) >= eff_h) ? '0 : in_row_nx[RW-1:0];
            end else begin
               in_col_ff <= in_col_nx[CW-1:0];
            end
         end
         if (do_emit) begin
            if (DW'(out_col_nx) >= eff_w) begin
               out_col_ff  <= '0;
               out_slot_ff <= out_slot_nx;
               out_row_ff  <= (DW'(out_row_nx) >= eff_h) ? '0 : out_row_nx[RW-1:0];
            end else begin
               out_col_ff <= out_col_nx[CW-1:0];
            end
         end
         priority if (is_pix && !do_emit) begin
            pend_ff <= pend_inc;
         end else if (!is_pix && do_emit) begin
            pend_ff <= pend_ff - PW'(1);
         end
      end
   end

   // line store: one memory per slot
   logic [PIX_W-1:0] rd_col [SLOTS];
   logic [PIX_W-1:0] rd_brd [SLOTS];

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      wmf_line_buf #(
         .DEPTH (MAX_WIDTH),
         .AW    (CW)
      ) u_line_buf (
         .clock     (clock),
         .wr_en     (accept && is_pix && (in_slot_ff == SW'(s))),
         .wr_addr   (in_col_ff),
         .wr_data   (req_pixel_in),
         .rd_en     (accept),
         .rd_addr_a (in_col_ff),
         .rd_addr_b (out_col_ff),
         .rd_data_a (rd_col[s]),
         .rd_data_b (rd_brd[s])
      );
   end

   // stage 1: read data back from the store
   wmf_pkg::ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [SW-1:0]    s1_in_slot_ff;
   logic [SW-1:0]    s1_out_slot_ff;
   logic [PIX_W-1:0] s2_brd_ff, s3_brd_ff, s4_brd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   logic [PIX_W-1:0] s1_brd;

   assign s1_brd = s1_ctl_ff.bypass ? s1_pix_ff : rd_brd[s1_out_slot_ff];

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff.pix    <= is_pix;
         s1_ctl_ff.emit   <= do_emit;
         s1_ctl_ff.border <= is_border;
         s1_ctl_ff.last   <= is_last;
         s1_ctl_ff.bypass <= is_pix && (out_slot_ff == in_slot_ff) && (out_col_ff == in_col_ff);
         s1_pix_ff        <= req_pixel_in;
         s1_in_slot_ff    <= in_slot_ff;
         s1_out_slot_ff   <= out_slot_ff;
         s2_ctl_ff        <= s1_ctl_ff;
         s2_brd_ff        <= s1_brd;
         s3_ctl_ff        <= s2_ctl_ff;
         s3_brd_ff        <= s2_brd_ff;
         s4_ctl_ff        <= s3_ctl_ff;
         s4_brd_ff        <= s3_brd_ff;
      end
   end

   // new window column: oldest row first, newest row from the input pixel;
   // a flush takes the newest row from the store as it stands
   logic [PIX_W-1:0] new_col [WR];

   always_comb begin
      int sel;
      for (int r = 0; r < WR; r++) begin
         sel = int'(s1_in_slot_ff) + SLOTS - (WR - 1) + r;
         if (sel >= SLOTS) sel = sel - SLOTS;
         new_col[r] = ((r == WR - 1) && s1_ctl_ff.pix) ? s1_pix_ff : rd_col[SW'(sel)];
      end
   end

   // column held beside the window for a flush at stage 2
   logic [PIX_W-1:0] s2_col_ff [WR];

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_col_ff <= new_col;
      end
   end

   // window: chain of cell columns
   logic [PIX_W-1:0] win_col [WC+1][WR];
   logic             win_shift;
   logic [PIX_W-1:0] win_flat [N];

   assign win_shift  = adv && s1_vld_ff && s1_ctl_ff.pix;
   assign win_col[0] = new_col;

   // a flush sees the window as if its store column had shifted in
   for (genvar c = 0; c < WC; c++) begin : g_col
      wmf_win_col #(
         .ROWS (WR)
      ) u_win_col (
         .clock   (clock),
         .reset   (reset),
         .shift   (win_shift),
         .col_in  (win_col[c]),
         .col_out (win_col[c+1])
      );
      for (genvar r = 0; r < WR; r++) begin : g_row
         assign win_flat[r * WC + c] = s2_ctl_ff.pix ? win_col[c+1][r] :
                                       ((c == 0) ? s2_col_ff[r] : win_col[c][r]);
      end
   end

   // median over the window held at stage 2
   logic [PIX_W-1:0] median;

   wmf_median #(
      .N (N)
   ) u_median (
      .clock  (clock),
      .en     (adv),
      .win    (win_flat),
      .median (median)
   );

   // output register
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_vld_ff && s4_ctl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pixel_ff <= s4_ctl_ff.border ? s4_brd_ff : median;
         rsp_last_ff  <= s4_ctl_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

   // pending count never passes the largest possible lag
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PW'(PEND_MAX))
      else $error("pending count out of range");

   // a held result freezes the whole pipeline
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable({s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff}))
      else $error("pipeline moved under a held result");

   // input and output columns stay inside the line store
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (DW'(in_col_ff) < DW'(MAX_WIDTH)) && (DW'(out_col_ff) < DW'(MAX_WIDTH)))
      else $error("column counter beyond line store");

   // a flush never writes the store, so the window must not shift for it
   a_flush_noshift: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_ctl_ff.pix) |-> !win_shift)
      else $error("window shifted for a flush transfer");

endmodule
